[hdl/dncd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dncd_pkg: shared types and constants of the day number to date converter
// Calendar constants, sequencer state codes, step operation codes and the
// month length function used by the date stepping unit.
// ----------------------------------------------------------------------------
package dncd_pkg;

  localparam int unsigned YEAR_W  = 23;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned OUT_W   = 40;

  // Largest year; the date never leaves this year once it gets there.
  localparam logic [YEAR_W-1:0] YEAR_MAX    = 23'd8388607;
  localparam logic [YEAR_W-1:0] BC_START    = 23'd4713;
  localparam logic [YEAR_W-1:0] REFORM_YEAR = 23'd1582;

  localparam logic [17:0] GREG_CYCLE_DAYS  = 18'd146097;
  localparam logic [17:0] JUL_CYCLE_DAYS   = 18'd1461;
  localparam logic [8:0]  GREG_CYCLE_YEARS = 9'd400;
  localparam logic [8:0]  JUL_CYCLE_YEARS  = 9'd4;
  localparam logic [8:0]  COMMON_YEAR_DAYS = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_DAYS   = 9'd366;
  localparam logic [8:0]  REFORM_YEAR_DAYS = 9'd355;
  localparam logic [4:0]  REFORM_OCT_DAYS  = 5'd21;
  localparam logic [4:0]  REFORM_LAST_DAY  = 5'd4;
  localparam logic [4:0]  REFORM_NEXT_DAY  = 5'd15;

  localparam logic [8:0] CENTURY_1 = 9'd100;
  localparam logic [8:0] CENTURY_2 = 9'd200;
  localparam logic [8:0] CENTURY_3 = 9'd300;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_MOD  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOD,
    OP_GREG,
    OP_JUL,
    OP_YEAR,
    OP_MONTH,
    OP_DAY
  } step_op_e;

  // Number of the last day of a month.
  function automatic logic [DAY_W-1:0] month_last_day(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
    logic [DAY_W-1:0] last;
    case (month)
      MONTH_FEB: last = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: last = 5'd30;
      default: last = 5'd31;
    endcase
    return last;
  endfunction

endpackage

[hdl/day_number_to_calendar_date_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_number_to_calendar_date_unit: day number to Julian/Gregorian date
// Advances a stored calendar date by the distance between successive day
// numbers and returns day of month, month, year and a BC flag.
// ----------------------------------------------------------------------------
// Timing: an accepted day number moves the unit from the idle state to the
// stepping state, which runs the date steps; the done state then registers
// the result and raises m_axis_tvalid_o. One step covers a 400-year Gregorian
// cycle, a 4-year Julian cycle, a year, a month or a day. The shared stepping
// adder serves one item at a time: a new day number is taken only once the
// result has left the done state. Reaching the saturated year adds a
// shift-and-add reduction modulo 365. A stalled result holds the unit in place.
// Reset (rst_ni low, asynchronous) sets the date to 1 January 4713 BC and
// the previous day number to 0.
// ----------------------------------------------------------------------------

module day_number_to_calendar_date_unit #(
  parameter int unsigned DAY_NUMBER_BITS = 31
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: day_number [DAY_NUMBER_BITS-1:0], zero padding above.
  input  logic [((DAY_NUMBER_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // tdata: day_of_month [4:0], month [8:5], year [31:9], is_bc [32],
  // zero padding [39:33].
  output logic [dncd_pkg::OUT_W-1:0]               m_axis_tdata_o
);

  localparam int unsigned W  = DAY_NUMBER_BITS;
  localparam int unsigned CW = (W > 18) ? W : 18;

  // 2^17 leaves 37 modulo 365 and 2^9 leaves 147, so the upper part of the
  // remaining count folds onto the lower part without changing the residue.
  localparam int unsigned FOLD_WIDE_SHIFT  = 17;
  localparam int unsigned FOLD_SHORT_SHIFT = 9;
  localparam logic [W-1:0] FOLD_WIDE_MASK  = W'(32'h0001_FFFF);
  localparam logic [W-1:0] FOLD_SHORT_MASK = W'(32'h0000_01FF);

  dncd_pkg::state_e            state_q, state_d;
  logic [W-1:0]                rem_q, rem_d;
  logic [W-1:0]                last_q, last_d;
  logic [dncd_pkg::DAY_W-1:0]   day_q, day_d;
  logic [dncd_pkg::MONTH_W-1:0] month_q, month_d;
  logic [dncd_pkg::YEAR_W-1:0]  year_q, year_d;
  logic                        ad_q, ad_d;
  logic [8:0]                  y400_q, y400_d;
  logic                        out_valid_q, out_valid_d;
  logic [dncd_pkg::OUT_W-1:0]   out_data_q, out_data_d;

  logic [W-1:0]                target;
  logic                        in_fire;
  logic [CW-1:0]               rem_c;
  logic                        reform_year, gregorian, leap, jan1, at_max;
  logic                        greg_ok, jul_ok;
  logic [8:0]                  year_days;
  logic [dncd_pkg::DAY_W-1:0]   last_day;
  logic [dncd_pkg::DAY_W-1:0]   mstep_days;
  dncd_pkg::step_op_e          op;
  logic [17:0]                 step_days;
  logic [8:0]                  yadd;
  logic                        year_roll;
  logic [dncd_pkg::YEAR_W-1:0]  nyear;
  logic                        nad;
  logic [8:0]                  ny400;
  logic [9:0]                  y400_sum;
  logic                        fold_wide, fold_short;
  logic [W-1:0]                fold_hi, fold_lo, fold_sum;

  assign target          = s_axis_tdata_i[W-1:0];
  assign s_axis_tready_o = (state_q == dncd_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Calendar facts about the current date.
  assign rem_c       = CW'(rem_q);
  assign reform_year = ad_q && (year_q == dncd_pkg::REFORM_YEAR);
  assign gregorian   = ad_q && (year_q > dncd_pkg::REFORM_YEAR);
  assign jan1        = (day_q == 5'd1) && (month_q == dncd_pkg::MONTH_JAN);
  assign at_max      = ad_q && (year_q == dncd_pkg::YEAR_MAX);

  always_comb begin
    if (!ad_q) begin
      // Julian leap years in the BC era are 1, 5, 9 BC and so on.
      leap = (year_q[1:0] == 2'b01);
    end else if (!gregorian) begin
      leap = (year_q[1:0] == 2'b00);
    end else begin
      leap = (year_q[1:0] == 2'b00) && (y400_q != dncd_pkg::CENTURY_1) &&
             (y400_q != dncd_pkg::CENTURY_2) && (y400_q != dncd_pkg::CENTURY_3);
    end
  end

  assign year_days  = reform_year ? dncd_pkg::REFORM_YEAR_DAYS :
                      (leap ? dncd_pkg::LEAP_YEAR_DAYS : dncd_pkg::COMMON_YEAR_DAYS);
  assign last_day   = dncd_pkg::month_last_day(month_q, leap);
  // October 1582 lost ten days, so a whole-month step there is shorter.
  assign mstep_days = (reform_year && (month_q == dncd_pkg::MONTH_OCT)) ?
                      dncd_pkg::REFORM_OCT_DAYS : last_day;

  // A 400-year jump must stay in the Gregorian era and below the year limit;
  // a 4-year jump must not reach into the reform year.
  assign greg_ok = gregorian &&
                   (year_q <= dncd_pkg::YEAR_MAX - 23'(dncd_pkg::GREG_CYCLE_YEARS));
  assign jul_ok  = (!ad_q && (year_q >= 23'd5)) ||
                   (ad_q && (year_q <= dncd_pkg::REFORM_YEAR -
                                       23'(dncd_pkg::JUL_CYCLE_YEARS)));

  // Pick the largest step that the remaining day count allows.
  always_comb begin
    if (rem_q == '0) begin
      op = dncd_pkg::OP_NONE;
    end else if (jan1 && at_max && (rem_c >= CW'(dncd_pkg::COMMON_YEAR_DAYS))) begin
      op = dncd_pkg::OP_MOD;
    end else if (jan1 && greg_ok && (rem_c >= CW'(dncd_pkg::GREG_CYCLE_DAYS))) begin
      op = dncd_pkg::OP_GREG;
    end else if (jan1 && jul_ok && (rem_c >= CW'(dncd_pkg::JUL_CYCLE_DAYS))) begin
      op = dncd_pkg::OP_JUL;
    end else if (jan1 && (rem_c >= CW'(year_days))) begin
      op = dncd_pkg::OP_YEAR;
    end else if ((day_q == 5'd1) && (rem_c >= CW'(mstep_days))) begin
      op = dncd_pkg::OP_MONTH;
    end else begin
      op = dncd_pkg::OP_DAY;
    end
  end

  always_comb begin
    case (op)
      dncd_pkg::OP_GREG:  step_days = dncd_pkg::GREG_CYCLE_DAYS;
      dncd_pkg::OP_JUL:   step_days = dncd_pkg::JUL_CYCLE_DAYS;
      dncd_pkg::OP_YEAR:  step_days = 18'(year_days);
      dncd_pkg::OP_MONTH: step_days = 18'(mstep_days);
      dncd_pkg::OP_DAY:   step_days = 18'd1;
      default:            step_days = '0;
    endcase
  end

  always_comb begin
    case (op)
      dncd_pkg::OP_GREG: yadd = dncd_pkg::GREG_CYCLE_YEARS;
      dncd_pkg::OP_JUL:  yadd = dncd_pkg::JUL_CYCLE_YEARS;
      default:           yadd = 9'd1;
    endcase
  end

  assign year_roll = (op == dncd_pkg::OP_GREG) || (op == dncd_pkg::OP_JUL) ||
                     (op == dncd_pkg::OP_YEAR) ||
                     ((op == dncd_pkg::OP_MONTH) && (month_q == dncd_pkg::MONTH_DEC)) ||
                     ((op == dncd_pkg::OP_DAY) && (month_q == dncd_pkg::MONTH_DEC) &&
                      (day_q == last_day));

  // Shared year adder. The year modulo 400 is kept beside the year so that
  // the Gregorian century rule needs no division.
  assign y400_sum = {1'b0, y400_q} + {1'b0, yadd};

  always_comb begin
    nyear = year_q;
    nad   = ad_q;
    ny400 = y400_q;
    if (!ad_q) begin
      if (year_q == 23'd1) begin
        // 1 BC is followed by AD 1.
        nad   = 1'b1;
        nyear = 23'd1;
        ny400 = 9'd1;
      end else begin
        nyear = year_q - 23'(yadd);
      end
    end else if (!at_max) begin
      nyear = year_q + 23'(yadd);
      ny400 = (y400_sum >= {1'b0, dncd_pkg::GREG_CYCLE_YEARS}) ?
              9'(y400_sum - {1'b0, dncd_pkg::GREG_CYCLE_YEARS}) : y400_sum[8:0];
    end
  end

  // One fold of the modulo 365 reduction: the part from bit 17 up (or from bit 9
  // once the count is small) is multiplied by its residue with shifts and
  // added back to the low part. Every fold shrinks the count.
  assign fold_wide  = ((rem_q >> FOLD_WIDE_SHIFT) != '0);
  assign fold_short = ((rem_q >> FOLD_SHORT_SHIFT) != '0);

  always_comb begin
    if (fold_wide) begin
      fold_hi  = rem_q >> FOLD_WIDE_SHIFT;
      fold_lo  = rem_q & FOLD_WIDE_MASK;
      fold_sum = (fold_hi << 5) + (fold_hi << 2) + fold_hi + fold_lo;
    end else begin
      fold_hi  = rem_q >> FOLD_SHORT_SHIFT;
      fold_lo  = rem_q & FOLD_SHORT_MASK;
      fold_sum = (fold_hi << 7) + (fold_hi << 4) + (fold_hi << 1) + fold_hi + fold_lo;
    end
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    last_d      = last_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    ad_d        = ad_q;
    y400_d      = y400_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dncd_pkg::ST_IDLE: begin
        if (in_fire) begin
          // A day number below the previous one leaves the date in place.
          rem_d   = (target > last_q) ? (target - last_q) : '0;
          last_d  = target;
          state_d = dncd_pkg::ST_RUN;
        end
      end
      dncd_pkg::ST_RUN: begin
        if (op == dncd_pkg::OP_NONE) begin
          state_d = dncd_pkg::ST_DONE;
        end else if (op == dncd_pkg::OP_MOD) begin
          // In the saturated year only the remainder modulo 365 matters.
          state_d = dncd_pkg::ST_MOD;
        end else begin
          rem_d = rem_q - W'(step_days);
          if (op == dncd_pkg::OP_MONTH) begin
            month_d = (month_q == dncd_pkg::MONTH_DEC) ? dncd_pkg::MONTH_JAN :
                      month_q + 4'd1;
          end else if (op == dncd_pkg::OP_DAY) begin
            if (reform_year && (month_q == dncd_pkg::MONTH_OCT) &&
                (day_q == dncd_pkg::REFORM_LAST_DAY)) begin
              day_d = dncd_pkg::REFORM_NEXT_DAY;
            end else if (day_q == last_day) begin
              day_d   = 5'd1;
              month_d = (month_q == dncd_pkg::MONTH_DEC) ? dncd_pkg::MONTH_JAN :
                        month_q + 4'd1;
            end else begin
              day_d = day_q + 5'd1;
            end
          end
          if (year_roll) begin
            year_d = nyear;
            ad_d   = nad;
            y400_d = ny400;
          end
        end
      end
      dncd_pkg::ST_MOD: begin
        if (fold_short) begin
          rem_d = fold_sum;
        end else begin
          // Below 512 a single subtraction finishes the reduction.
          rem_d   = (rem_q >= W'(dncd_pkg::COMMON_YEAR_DAYS)) ?
                    (rem_q - W'(dncd_pkg::COMMON_YEAR_DAYS)) : rem_q;
          state_d = dncd_pkg::ST_RUN;
        end
      end
      dncd_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'b0, !ad_q, year_q, month_q, day_q};
          state_d     = dncd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dncd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dncd_pkg::ST_IDLE;
      rem_q       <= '0;
      last_q      <= '0;
      day_q       <= 5'd1;
      month_q     <= dncd_pkg::MONTH_JAN;
      year_q      <= dncd_pkg::BC_START;
      ad_q        <= 1'b0;
      y400_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      last_q      <= last_d;
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      ad_q        <= ad_d;
      y400_q      <= y400_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the day number to calendar date unit
// Streams day numbers into the unit and checks every returned date against a
// calendar predictor kept in the bench. A directed opening walks across the
// first days of 4713 BC, a BC leap day, the 1 BC to AD 1 change, the 1582
// reform gap and the century leap rules. A random middle part mixes short day
// walks, leap and month end landings, backward day numbers and long jumps. A
// closing part drives the extreme day numbers until the year saturates, then
// wraps around the last year. Both sides stall at random in phases.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned DAY_W   = dncd_pkg::DAY_W;
  localparam int unsigned MONTH_W = dncd_pkg::MONTH_W;
  localparam int unsigned YEAR_W  = dncd_pkg::YEAR_W;

  localparam int unsigned DN_W = 31;
  localparam int unsigned IN_W = ((DN_W + 7) / 8) * 8;
  localparam longint unsigned DN_MAX = (64'd1 << DN_W) - 1;
  localparam longint unsigned GREG_FIRST_DAY = 64'd2299161;
  localparam int unsigned RANDOM_END = 632;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned QUIET_LIMIT = 200000;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               ad;
    logic [DN_W-1:0]    last;
  } cal_t;

  localparam cal_t CAL_AT_RESET = '{day: 5'd1, month: dncd_pkg::MONTH_JAN,
                                    year: dncd_pkg::BC_START, ad: 1'b0, last: '0};

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [dncd_pkg::OUT_W-1:0] m_axis_tdata;

  logic [DN_W-1:0] day_numbers_to_send[$];
  cal_t            expected_dates[$];
  cal_t            gen_cal;
  cal_t            dut_cal;
  int unsigned     total_items = 0;
  int unsigned     accepted_items = 0;
  int unsigned     fail_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;

  day_number_to_calendar_date_unit #(
    .DAY_NUMBER_BITS(DN_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Day count of a valid date, day 0 being 1 January 4713 BC.
  function automatic longint unsigned day_count(input logic ad, input longint unsigned year,
                                                input longint unsigned month,
                                                input longint unsigned day);
    longint unsigned a;
    longint unsigned mm;
    longint unsigned yy;
    longint unsigned base;
    logic            greg;
    a = (month <= 2) ? 1 : 0;
    mm = month + 12 * a - 3;
    yy = ad ? year + 4800 - a : 4801 - year - a;
    base = day + (153 * mm + 2) / 5 + 365 * yy + yy / 4;
    greg = ad && (year > dncd_pkg::REFORM_YEAR ||
                  (year == dncd_pkg::REFORM_YEAR && (month > dncd_pkg::MONTH_OCT ||
                   (month == dncd_pkg::MONTH_OCT && day >= dncd_pkg::REFORM_NEXT_DAY))));
    if (greg) begin
      return base - yy / 100 + yy / 400 - 32045;
    end
    return base - 32083;
  endfunction

  // Moves the date forward by the rise of the day number; a fall leaves the
  // date alone but still becomes the new reference.
  function automatic cal_t step_calendar(input cal_t cur, input logic [DN_W-1:0] dn);
    longint unsigned j;
    longint unsigned ystart;
    longint unsigned yend;
    longint unsigned f;
    longint unsigned e;
    longint unsigned g;
    longint unsigned h;
    longint unsigned m;
    longint unsigned yp;
    cal_t            nxt;
    nxt = cur;
    if (dn > cur.last) begin
      j = day_count(cur.ad, cur.year, cur.month, cur.day) + (dn - cur.last);
      ystart = day_count(1'b1, dncd_pkg::YEAR_MAX, 1, 1);
      yend = day_count(1'b1, dncd_pkg::YEAR_MAX, 12, 31);
      // Past the last year the date keeps cycling through that year.
      if (j > yend) begin
        j = ystart + (j - ystart) % (yend - ystart + 1);
      end
      f = j + 1401;
      if (j >= GREG_FIRST_DAY) begin
        f = f + (((4 * j + 274277) / 146097) * 3) / 4 - 38;
      end
      e = 4 * f + 3;
      g = (e % 1461) / 4;
      h = 5 * g + 2;
      nxt.day = DAY_W'((h % 153) / 5 + 1);
      m = (h / 153 + 2) % 12 + 1;
      nxt.month = MONTH_W'(m);
      yp = e / 1461 + (14 - m) / 12;
      if (yp >= 4717) begin
        nxt.ad = 1'b1;
        nxt.year = YEAR_W'(yp - 4716);
      end else begin
        nxt.ad = 1'b0;
        nxt.year = YEAR_W'(4717 - yp);
      end
    end
    nxt.last = dn;
    return nxt;
  endfunction

  // Stimulus building: gen_cal tracks the date the unit will hold so that
  // landings on chosen calendar dates can be computed.
  task automatic queue_day(input longint unsigned dn);
    day_numbers_to_send.push_back(DN_W'(dn));
    gen_cal = step_calendar(gen_cal, DN_W'(dn));
  endtask

  task automatic advance_by(input longint unsigned delta);
    if (longint'(gen_cal.last) + delta > DN_MAX) begin
      queue_day(0);
    end
    queue_day(longint'(gen_cal.last) + delta);
  endtask

  task automatic land_on(input logic ad, input longint unsigned year,
                         input longint unsigned month, input longint unsigned day,
                         input longint unsigned lead);
    longint unsigned goal;
    longint unsigned here;
    goal = day_count(ad, year, month, day) - lead;
    here = day_count(gen_cal.ad, gen_cal.year, gen_cal.month, gen_cal.day);
    if (goal > here) begin
      advance_by(goal - here);
    end
  endtask

  always_comb begin
    if (accepted_items * 3 < total_items) begin
      send_idle_pct = 11;
      recv_idle_pct = 56;
    end else if (accepted_items * 3 < total_items * 2) begin
      send_idle_pct = 56;
      recv_idle_pct = 11;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Driver: the expected date is worked out when the unit takes the transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        dut_cal = step_calendar(dut_cal, s_axis_tdata[DN_W-1:0]);
        expected_dates.push_back(dut_cal);
        accepted_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (day_numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_W - DN_W){1'b0}}, day_numbers_to_send.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each returned date is held against the oldest expected one.
  always @(posedge clk_i) begin
    cal_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dates.size() == 0) begin
          $error("date returned with none expected: 0x%010h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          if (m_axis_tdata[4:0] !== want.day) begin
            $error("day_of_month: expected %0d, got %0d", want.day, m_axis_tdata[4:0]);
            fail_count++;
          end
          if (m_axis_tdata[8:5] !== want.month) begin
            $error("month: expected %0d, got %0d", want.month, m_axis_tdata[8:5]);
            fail_count++;
          end
          if (m_axis_tdata[31:9] !== want.year) begin
            $error("year: expected %0d, got %0d", want.year, m_axis_tdata[31:9]);
            fail_count++;
          end
          if (m_axis_tdata[32] !== !want.ad) begin
            $error("is_bc: expected %0d, got %0d", !want.ad, m_axis_tdata[32]);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    longint unsigned yr;
    int unsigned     n;
    gen_cal = CAL_AT_RESET;
    dut_cal = CAL_AT_RESET;

    // Opening days of 4713 BC: same day number, one day on, the BC leap day
    // and a backward day number that must leave the date alone.
    queue_day(0);
    advance_by(1);
    land_on(1'b0, dncd_pkg::BC_START, dncd_pkg::MONTH_FEB, 28, 0);
    advance_by(1);
    advance_by(1);
    queue_day(5);
    advance_by(305);
    // 1 BC is a leap year and is followed directly by AD 1.
    land_on(1'b0, 1, dncd_pkg::MONTH_FEB, 29, 1);
    advance_by(1);
    advance_by(1);
    land_on(1'b0, 1, dncd_pkg::MONTH_DEC, 31, 0);
    advance_by(1);
    land_on(1'b1, 4, dncd_pkg::MONTH_FEB, 28, 0);
    advance_by(1);
    // Reform gap: 4 October 1582 is followed by 15 October.
    land_on(1'b1, dncd_pkg::REFORM_YEAR, dncd_pkg::MONTH_OCT, dncd_pkg::REFORM_LAST_DAY, 0);
    advance_by(1);
    advance_by(1);
    land_on(1'b1, 1600, dncd_pkg::MONTH_FEB, 29, 0);
    advance_by(1);
    land_on(1'b1, 1700, dncd_pkg::MONTH_FEB, 28, 0);
    advance_by(1);
    land_on(1'b1, 2000, dncd_pkg::MONTH_FEB, 29, 0);

    while (day_numbers_to_send.size() < RANDOM_END) begin
      n = $urandom_range(99);
      if (n < 45) begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(19))
            0:       advance_by(0);
            1, 2, 3: advance_by($urandom_range(0, 800));
            4, 5, 6, 7, 8, 9: advance_by($urandom_range(300, 400));
            default: advance_by($urandom_range(1, 40));
          endcase
        end
      end else if (n < 60) begin
        land_on(1'b1, gen_cal.year + $urandom_range(1, 300), dncd_pkg::MONTH_FEB, 28,
                $urandom_range(0, 2));
        repeat (3) advance_by(1);
      end else if (n < 70) begin
        // Century years: leap only when divisible by 400.
        yr = (gen_cal.year / 100 + $urandom_range(1, 4)) * 100;
        land_on(1'b1, yr, dncd_pkg::MONTH_FEB, 28, 1);
        repeat (3) advance_by(1);
      end else if (n < 80) begin
        land_on(1'b1, gen_cal.year + $urandom_range(0, 1), $urandom_range(1, 12), 28, 0);
        repeat (4) advance_by(1);
      end else if (n < 90) begin
        repeat ($urandom_range(1, 3)) queue_day($urandom_range(0, gen_cal.last));
      end else begin
        advance_by($urandom_range(1000, 400000));
      end
    end

    // Extreme day numbers, repeated until the year saturates.
    while (!(gen_cal.ad && gen_cal.year == dncd_pkg::YEAR_MAX)) begin
      queue_day(0);
      queue_day(DN_MAX);
    end
    queue_day(31'h2AAAAAAA);
    queue_day(31'h55555555);
    // The saturated year wraps from 31 December back to 1 January.
    land_on(1'b1, dncd_pkg::YEAR_MAX, dncd_pkg::MONTH_DEC, 31, 1);
    repeat (3) advance_by(1);
    repeat (5) advance_by($urandom_range(1, 100000));

    total_items = day_numbers_to_send.size();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items < total_items || expected_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
